// ===== hdl/mkvt_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mkvt_pkg: shared types for the MAC key/value table
// Operation codes and the transaction token that moves down the cell chain.
// ----------------------------------------------------------------------------
package mkvt_pkg;

  localparam int unsigned KeyWidth   = 48;
  localparam int unsigned ValueWidth = 32;
  localparam int unsigned SlotWidth  = 6;

  typedef enum logic {
    OP_FIND = 1'b0,
    OP_ADD  = 1'b1
  } op_e;

  // One lookup/update transaction in flight along the chain.
  typedef struct packed {
    logic                         valid;
    op_e                          op;
    logic                         hit;    // key matched a filled entry
    logic                         added;  // key appended at the tail cell
    logic [KeyWidth-1:0]          key;
    logic signed [ValueWidth-1:0] new_value;
    logic signed [ValueWidth-1:0] value;  // running result value
  } token_t;

endpackage

// ===== hdl/mkvt_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mkvt_cell: one table entry of the key/value chain
// Holds one key and value, checks the passing transaction, registers it on.
// ----------------------------------------------------------------------------
module mkvt_cell
  import mkvt_pkg::*;
#(
  parameter int unsigned INDEX = 0,
  parameter int unsigned IDX_W = 6,
  parameter int unsigned CNT_W = 7
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [CNT_W-1:0] count_i,
  input  token_t           tok_i,
  input  logic [IDX_W-1:0] slot_i,
  output token_t           tok_o,
  output logic [IDX_W-1:0] slot_o
);

  logic [KeyWidth-1:0]          key_q;
  logic signed [ValueWidth-1:0] value_q;
  token_t                       tok_d, tok_q;
  logic [IDX_W-1:0]             slot_d, slot_q;
  logic                         filled, at_tail, match, append;

  assign filled  = count_i > CNT_W'(INDEX);
  assign at_tail = count_i == CNT_W'(INDEX);
  assign match   = tok_i.valid && !tok_i.hit && filled && (key_q == tok_i.key);
  assign append  = tok_i.valid && (tok_i.op == OP_ADD) && !tok_i.hit && at_tail;

  always_comb begin
    tok_d  = tok_i;
    slot_d = slot_i;
    if (match) begin
      tok_d.hit = 1'b1;
      slot_d    = IDX_W'(INDEX);
      if (tok_i.op == OP_FIND) begin
        tok_d.value = value_q;
      end
    end
    if (append) begin
      tok_d.added = 1'b1;
      slot_d      = IDX_W'(INDEX);
    end
  end

  // Entry storage: written on append, value rewritten on an update hit.
  always_ff @(posedge clk_i) begin
    if (append) begin
      key_q <= tok_i.key;
    end
    if (append || (match && (tok_i.op == OP_ADD))) begin
      value_q <= tok_i.new_value;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q.valid <= 1'b0;
    end else begin
      tok_q <= tok_d;
    end
  end

  always_ff @(posedge clk_i) begin
    slot_q <= slot_d;
  end

  assign tok_o  = tok_q;
  assign slot_o = slot_q;

endmodule

// ===== hdl/mac_key_value_table.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mac_key_value_table: associative table of 48-bit keys with 32-bit values
// Find returns the stored value or a default; add updates, appends, or is refused when full.
// ----------------------------------------------------------------------------
// Timing: done_o rises once the accepted transaction has passed the entry
//   register, every cell register of the chain and the done register.
// Throughput: one transaction at a time (start_i is ignored while busy_o is high);
//   it walks the cell chain one entry per cycle, so the chain length sets the rate.
// busy_o is high from acceptance until the result cycle.
// Reset: the entry count and all control clear at once; entries need no clear.
// The receiver cannot stall: each result is valid for exactly one cycle.
module mac_key_value_table
  import mkvt_pkg::*;
#(
  parameter int unsigned CAPACITY = 64
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  output logic                         busy_o,
  input  logic                         op_i,
  input  logic [KeyWidth-1:0]          key_i,
  input  logic signed [ValueWidth-1:0] new_value_i,
  input  logic signed [ValueWidth-1:0] default_value_i,
  output logic                         done_o,
  output logic                         found_o,
  output logic [SlotWidth-1:0]         slot_o,
  output logic signed [ValueWidth-1:0] result_value_o,
  output logic                         table_full_o
);

  localparam int unsigned IdxW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CntW = $clog2(CAPACITY + 1);

  // Chain links: link 0 is the entry register, link CAPACITY leaves the last cell.
  token_t          tok_w  [CAPACITY+1];
  logic [IdxW-1:0] slot_w [CAPACITY+1];

  token_t                       tok0_q;
  logic                         busy_q, busy_d;
  logic [CntW-1:0]              count_q, count_d;
  logic                         done_q;
  logic                         found_q, full_q;
  logic [SlotWidth-1:0]         slot_q;
  logic signed [ValueWidth-1:0] value_q;
  logic                         accept;
  token_t                       tail;
  logic                         tail_full;

  assign accept = start_i && !busy_q;

  // Load the transaction into the head of the chain; a find starts with the
  // default as its value, an add with the value it stores.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok0_q.valid <= 1'b0;
    end else begin
      tok0_q.valid     <= accept;
      tok0_q.op        <= op_e'(op_i);
      tok0_q.hit       <= 1'b0;
      tok0_q.added     <= 1'b0;
      tok0_q.key       <= key_i;
      tok0_q.new_value <= new_value_i;
      tok0_q.value     <= (op_i == OP_ADD) ? new_value_i : default_value_i;
    end
  end

  assign tok_w[0]  = tok0_q;
  assign slot_w[0] = '0;

  for (genvar gi = 0; gi < CAPACITY; gi++) begin : g_cell
    mkvt_cell #(
      .INDEX (gi),
      .IDX_W (IdxW),
      .CNT_W (CntW)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .count_i (count_q),
      .tok_i   (tok_w[gi]),
      .slot_i  (slot_w[gi]),
      .tok_o   (tok_w[gi+1]),
      .slot_o  (slot_w[gi+1])
    );
  end

  assign tail      = tok_w[CAPACITY];
  // An add that neither matched nor found a free tail cell is refused.
  assign tail_full = (tail.op == OP_ADD) && !tail.hit && !tail.added;

  // Hold busy from acceptance until the transaction leaves the chain; bump
  // the fill count when the transaction appended an entry.
  always_comb begin
    busy_d  = busy_q;
    count_d = count_q;
    if (accept) begin
      busy_d = 1'b1;
    end
    if (tail.valid) begin
      busy_d = 1'b0;
      if (tail.added) begin
        count_d = count_q + CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      count_q <= '0;
      done_q  <= 1'b0;
    end else begin
      busy_q  <= busy_d;
      count_q <= count_d;
      done_q  <= tail.valid;
    end
  end

  // Result register: slot carries the low bits of the entry index.
  always_ff @(posedge clk_i) begin
    found_q <= tail.hit;
    full_q  <= tail_full;
    slot_q  <= SlotWidth'(slot_w[CAPACITY]);
    value_q <= tail_full ? '0 : tail.value;
  end

  assign busy_o         = busy_q;
  assign done_o         = done_q;
  assign found_o        = found_q;
  assign slot_o         = slot_q;
  assign result_value_o = value_q;
  assign table_full_o   = full_q;

`ifndef SYNTHESIS
  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(CAPACITY))
    else $error("entry count exceeds capacity");

  a_busy_after_accept : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> busy_q)
    else $error("busy not raised after accepted transaction");

  a_done_frees : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !busy_q)
    else $error("result delivered while still busy");

  a_full_only_when_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_q && full_q) |-> (count_q == CntW'(CAPACITY)))
    else $error("add refused while entries remain free");
`endif

endmodule
